@@ sv/mbe_pkg.sv @@
// mbe_pkg: shared widths, register indexes, controller states and the
// command and status bundles of the escape-time counter.
// No dependencies.
`timescale 1ns / 1ps

package mbe_pkg;

    localparam int FRAC_BITS = 28;
    localparam int DIM_BITS  = 12;

    localparam int PIX_W     = 12;
    localparam int CFG_W     = 32;
    localparam int SIZE_W    = 13;
    localparam int LIMIT_W   = 16;
    localparam int IDX_W     = 3;

    // dividend: 33 bit magnitude of (max - min) times the coordinate
    localparam int DW        = 33 + DIM_BITS;
    localparam int DIV_CNT_W = $clog2(DW);
    // z register width: holds c (32 bit) plus a squared term up to 4.0
    localparam int ZW        = ((FRAC_BITS + 3 > 32) ? FRAC_BITS + 3 : 32) + 1;
    // multiplier operand width: magnitudes up to 2.0
    localparam int MW        = FRAC_BITS + 2;
    localparam int PW        = 2 * MW;

    typedef enum logic [IDX_W-1:0] {
        REG_RE_LO      = 3'd0,
        REG_RE_HI      = 3'd1,
        REG_IM_LO      = 3'd2,
        REG_IM_HI      = 3'd3,
        REG_WIDTH      = 3'd4,
        REG_HEIGHT     = 3'd5,
        REG_ITER_LIMIT = 3'd6
    } mbe_reg_idx_t;

    typedef struct packed {
        logic signed [CFG_W-1:0] re_lo;
        logic signed [CFG_W-1:0] re_hi;
        logic signed [CFG_W-1:0] im_lo;
        logic signed [CFG_W-1:0] im_hi;
        logic [SIZE_W-1:0]       image_width;
        logic [SIZE_W-1:0]       image_height;
        logic [LIMIT_W-1:0]      iteration_limit;
    } mbe_cfg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_MAP,
        ST_TEST,
        ST_UPD,
        ST_DONE
    } mbe_state_t;

    typedef struct packed {
        logic load_in;
        logic mul;
        logic div_step;
        logic load_c;
        logic iter_a;
        logic iter_b;
        logic load_out;
    } mbe_cmd_t;

    typedef struct packed {
        logic escape;
        logic at_limit;
    } mbe_status_t;

endpackage

@@ sv/mbe_regs.sv @@
// mbe_regs: configuration register file, written by index.
// Depends on mbe_pkg.
`timescale 1ns / 1ps

module mbe_regs (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         wr_en,
    input  logic [mbe_pkg::IDX_W-1:0]    wr_index,
    input  logic [mbe_pkg::CFG_W-1:0]    wr_data,
    output mbe_pkg::mbe_cfg_t            cfg
);

    mbe_pkg::mbe_cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.re_lo           <= 32'shE0000000;
            cfg_reg.re_hi           <= 32'sh20000000;
            cfg_reg.im_lo           <= 32'shE8000000;
            cfg_reg.im_hi           <= 32'sh18000000;
            cfg_reg.image_width     <= 13'd640;
            cfg_reg.image_height    <= 13'd480;
            cfg_reg.iteration_limit <= 16'd256;
        end
        else if (wr_en)
        begin
            case (mbe_pkg::mbe_reg_idx_t'(wr_index))
                mbe_pkg::REG_RE_LO:      cfg_reg.re_lo <= $signed(wr_data);
                mbe_pkg::REG_RE_HI:      cfg_reg.re_hi <= $signed(wr_data);
                mbe_pkg::REG_IM_LO:      cfg_reg.im_lo <= $signed(wr_data);
                mbe_pkg::REG_IM_HI:      cfg_reg.im_hi <= $signed(wr_data);
                mbe_pkg::REG_WIDTH:
                    cfg_reg.image_width <= wr_data[mbe_pkg::SIZE_W-1:0];
                mbe_pkg::REG_HEIGHT:
                    cfg_reg.image_height <= wr_data[mbe_pkg::SIZE_W-1:0];
                mbe_pkg::REG_ITER_LIMIT:
                    cfg_reg.iteration_limit <= wr_data[mbe_pkg::LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ sv/mbe_map.sv @@
// mbe_map: maps one pixel coordinate onto one axis of the complex plane:
// magnitude multiply, bit-serial restoring divide, signed add with saturation.
// Depends on mbe_pkg.
`timescale 1ns / 1ps

module mbe_map (
    input  logic                              clk,
    input  mbe_pkg::mbe_cmd_t                 cmd,
    input  logic signed [mbe_pkg::CFG_W-1:0]  lo,
    input  logic signed [mbe_pkg::CFG_W-1:0]  hi,
    input  logic [mbe_pkg::SIZE_W-1:0]        size,
    input  logic [mbe_pkg::PIX_W-1:0]         coord,
    output logic signed [mbe_pkg::ZW-1:0]     c
);

    localparam int DW = mbe_pkg::DW;
    localparam int SW = DW + 2;
    localparam int SZ = mbe_pkg::SIZE_W;

    logic signed [32:0]              diff;
    logic [32:0]                     absdiff;
    logic [32:0]                     absdiff_reg;
    logic                            neg_reg;
    logic signed [31:0]              lo_reg;
    logic [mbe_pkg::DIM_BITS-1:0]    coord_reg;

    logic [DW-1:0]                   dq_reg;
    logic [DW-1:0]                   dq_next;
    logic [SZ-1:0]                   rem_reg;
    logic [SZ-1:0]                   rem_next;
    logic [SZ:0]                     trial;
    logic                            ge;

    logic [DW-1:0]                   q;
    logic signed [SW-1:0]            off;
    logic signed [SW-1:0]            sum;
    logic signed [31:0]              c32;
    logic signed [mbe_pkg::ZW-1:0]   c_reg;

    assign diff    = {hi[31], hi} - {lo[31], lo};
    assign absdiff = diff[32] ? (~diff + 33'd1) : diff;

    // one quotient bit per step
    assign trial    = {rem_reg, dq_reg[DW-1]};
    assign ge       = trial >= {1'b0, size};
    assign rem_next = ge ? SZ'(trial - {1'b0, size}) : trial[SZ-1:0];
    assign dq_next  = {dq_reg[DW-2:0], ge};

    // zero size gives a zero offset
    assign q   = (size == '0) ? '0 : dq_reg;
    assign off = neg_reg ? -$signed({2'b00, q}) : $signed({2'b00, q});
    assign sum = $signed({{(SW-32){lo_reg[31]}}, lo_reg}) + off;

    always_comb
    begin
        if (sum[SW-1:31] == '0 || sum[SW-1:31] == '1)
            c32 = sum[31:0];
        else if (sum[SW-1])
            c32 = 32'sh80000000;
        else
            c32 = 32'sh7FFFFFFF;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            absdiff_reg <= absdiff;
            neg_reg     <= diff[32];
            lo_reg      <= lo;
            coord_reg   <= mbe_pkg::DIM_BITS'(coord);
        end
        if (cmd.mul)
        begin
            dq_reg  <= DW'(absdiff_reg * coord_reg);
            rem_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            dq_reg  <= dq_next;
            rem_reg <= rem_next;
        end
        if (cmd.load_c)
            c_reg <= mbe_pkg::ZW'(c32);
    end

    assign c = c_reg;

endmodule

@@ sv/mbe_dp.sv @@
// mbe_dp: datapath: both axis mappers, the z = z*z + c iteration split in
// a multiply stage and an update stage, iteration counter, result register.
// Depends on mbe_pkg and mbe_map.
`timescale 1ns / 1ps

module mbe_dp (
    input  logic                              clk,
    input  mbe_pkg::mbe_cmd_t                 cmd,
    input  mbe_pkg::mbe_cfg_t                 cfg,
    input  logic [mbe_pkg::PIX_W-1:0]         pixel_x,
    input  logic [mbe_pkg::PIX_W-1:0]         pixel_y,
    output mbe_pkg::mbe_status_t              status,
    output logic [mbe_pkg::LIMIT_W-1:0]       iteration_count,
    output logic                              reached_limit
);

    localparam int F  = mbe_pkg::FRAC_BITS;
    localparam int ZW = mbe_pkg::ZW;
    localparam int MW = mbe_pkg::MW;
    localparam int PW = mbe_pkg::PW;
    localparam logic [ZW-1:0] TWO  = ZW'(1) << (F + 1);
    localparam logic [PW:0]   FOUR = (PW + 1)'(1) << (2 * F + 2);

    logic signed [ZW-1:0]  cr;
    logic signed [ZW-1:0]  ci;
    logic signed [ZW-1:0]  zr_reg;
    logic signed [ZW-1:0]  zi_reg;
    logic [ZW-1:0]         ar;
    logic [ZW-1:0]         ai;

    logic [PW-1:0]         sr_reg;
    logic [PW-1:0]         si_reg;
    logic [PW-1:0]         cross_reg;
    logic                  big_reg;
    logic                  neg_reg;

    logic [PW:0]           mag_sum;
    logic                  escape;
    logic signed [PW:0]    d;
    logic signed [PW+1:0]  x;
    logic signed [ZW-1:0]  nr;
    logic signed [ZW-1:0]  ni;

    logic [mbe_pkg::LIMIT_W-1:0] count_reg;
    logic                        at_limit;
    logic [mbe_pkg::LIMIT_W-1:0] iteration_count_reg;
    logic                        reached_limit_reg;

    mbe_map u_map_re (
        .clk   (clk),
        .cmd   (cmd),
        .lo    (cfg.re_lo),
        .hi    (cfg.re_hi),
        .size  (cfg.image_width),
        .coord (pixel_x),
        .c     (cr)
    );

    mbe_map u_map_im (
        .clk   (clk),
        .cmd   (cmd),
        .lo    (cfg.im_lo),
        .hi    (cfg.im_hi),
        .size  (cfg.image_height),
        .coord (pixel_y),
        .c     (ci)
    );

    assign ar = zr_reg[ZW-1] ? ZW'(-zr_reg) : zr_reg;
    assign ai = zi_reg[ZW-1] ? ZW'(-zi_reg) : zi_reg;

    // update stage: escape test, then floor-scaled squares plus c
    assign mag_sum = {1'b0, sr_reg} + {1'b0, si_reg};
    assign escape  = big_reg || (mag_sum > FOUR);
    assign d  = $signed({1'b0, sr_reg}) - $signed({1'b0, si_reg});
    assign x  = neg_reg ? -$signed({1'b0, cross_reg, 1'b0}) :
                          $signed({1'b0, cross_reg, 1'b0});
    assign nr = ZW'(d >>> F);
    assign ni = ZW'(x >>> F);

    assign at_limit = count_reg == cfg.iteration_limit;

    always_ff @(posedge clk)
    begin
        if (cmd.load_c)
        begin
            zr_reg    <= '0;
            zi_reg    <= '0;
            count_reg <= '0;
        end
        else if (cmd.iter_b && !escape)
        begin
            zr_reg    <= nr + cr;
            zi_reg    <= ni + ci;
            count_reg <= count_reg + 1'b1;
        end
        if (cmd.iter_a)
        begin
            big_reg   <= (ar > TWO) || (ai > TWO);
            neg_reg   <= zr_reg[ZW-1] ^ zi_reg[ZW-1];
            sr_reg    <= ar[MW-1:0] * ar[MW-1:0];
            si_reg    <= ai[MW-1:0] * ai[MW-1:0];
            cross_reg <= ar[MW-1:0] * ai[MW-1:0];
        end
        if (cmd.load_out)
        begin
            iteration_count_reg <= count_reg;
            reached_limit_reg   <= at_limit;
        end
    end

    assign status.escape   = escape;
    assign status.at_limit = at_limit;
    assign iteration_count = iteration_count_reg;
    assign reached_limit   = reached_limit_reg;

endmodule

@@ sv/mbe_ctrl.sv @@
// mbe_ctrl: sequencer for map, divide and iteration phases, plus the
// input and output handshakes.
// Depends on mbe_pkg.
`timescale 1ns / 1ps

module mbe_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    output logic                  out_valid,
    input  logic                  out_ready,
    input  mbe_pkg::mbe_status_t  status,
    output mbe_pkg::mbe_cmd_t     cmd
);

    localparam logic [mbe_pkg::DIV_CNT_W-1:0] DIV_LAST =
        mbe_pkg::DIV_CNT_W'(mbe_pkg::DW - 1);

    mbe_pkg::mbe_state_t              state_reg;
    mbe_pkg::mbe_state_t              state_next;
    logic [mbe_pkg::DIV_CNT_W-1:0]    div_cnt_reg;
    logic [mbe_pkg::DIV_CNT_W-1:0]    div_cnt_next;
    logic                             out_valid_reg;
    logic                             out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mbe_pkg::ST_IDLE;
            div_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            div_cnt_reg   <= div_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        div_cnt_next   = div_cnt_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        in_ready       = 1'b0;

        case (state_reg)
            mbe_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = mbe_pkg::ST_MUL;
                end
            end
            mbe_pkg::ST_MUL:
            begin
                cmd.mul      = 1'b1;
                div_cnt_next = '0;
                state_next   = mbe_pkg::ST_DIV;
            end
            mbe_pkg::ST_DIV:
            begin
                cmd.div_step = 1'b1;
                div_cnt_next = div_cnt_reg + 1'b1;
                if (div_cnt_reg == DIV_LAST)
                    state_next = mbe_pkg::ST_MAP;
            end
            mbe_pkg::ST_MAP:
            begin
                cmd.load_c = 1'b1;
                state_next = mbe_pkg::ST_TEST;
            end
            mbe_pkg::ST_TEST:
            begin
                if (status.at_limit)
                    state_next = mbe_pkg::ST_DONE;
                else
                begin
                    cmd.iter_a = 1'b1;
                    state_next = mbe_pkg::ST_UPD;
                end
            end
            mbe_pkg::ST_UPD:
            begin
                cmd.iter_b = 1'b1;
                state_next = status.escape ? mbe_pkg::ST_DONE : mbe_pkg::ST_TEST;
            end
            mbe_pkg::ST_DONE:
            begin
                // wait for the result register to be free
                if (!out_valid_reg || out_ready)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = mbe_pkg::ST_IDLE;
                end
            end
            default:
                state_next = mbe_pkg::ST_IDLE;
        endcase
    end

    assign out_valid = out_valid_reg;

endmodule

@@ sv/mandelbrot_escape_count.sv @@
// mandelbrot_escape_count: escape-time count for one pixel per item.
// Sequence from accept to result valid: multiply, bit-serial coordinate divide, map,
// then per iteration a multiply step and an update step, until escape or limit.
// One item at a time: a new item is accepted only once the last result is loaded;
// a result may wait in its output register while the next item runs.
// Reset (async, active low) restores register defaults.
`timescale 1ns / 1ps

module mandelbrot_escape_count (
    input  logic                              clk,
    input  logic                              rst_n,

    // configuration write port
    input  logic                              wr_en,
    input  logic [mbe_pkg::IDX_W-1:0]         wr_index,
    input  logic [mbe_pkg::CFG_W-1:0]         wr_data,

    // input items: pixel coordinates
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [mbe_pkg::PIX_W-1:0]         pixel_x,
    input  logic [mbe_pkg::PIX_W-1:0]         pixel_y,

    // result items
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [mbe_pkg::LIMIT_W-1:0]       iteration_count,
    output logic                              reached_limit
);

    mbe_pkg::mbe_cfg_t     cfg;
    mbe_pkg::mbe_cmd_t     cmd;
    mbe_pkg::mbe_status_t  status;

    // Register file: axis bounds, image size, iteration limit.
    mbe_regs u_regs (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .cfg      (cfg)
    );

    // Sequencer: accept, multiply, divide, map, then alternate the multiply
    // and update stages of the iteration until escape or limit.
    mbe_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    // Datapath: the pixel fields are sampled on the accept cycle only.
    mbe_dp u_dp (
        .clk             (clk),
        .cmd             (cmd),
        .cfg             (cfg),
        .pixel_x         (pixel_x),
        .pixel_y         (pixel_y),
        .status          (status),
        .iteration_count (iteration_count),
        .reached_limit   (reached_limit)
    );

endmodule

@@ sim/mandelbrot_escape_count_test.sv @@
// Self-checking testbench for mandelbrot_escape_count: directed rows, then random pixel items.
// Results are checked against an in-bench escape-time predictor.
// Depends on mbe_pkg (widths, register indexes, config struct) and the DUT.
`timescale 1ns / 1ps

module mandelbrot_escape_count_test;
    import mbe_pkg::*;

    // Q4.28 helpers
    localparam int ONE   = 1 << FRAC_BITS;
    localparam int Q_MAX = 2147483647;
    localparam int Q_MIN = -2147483647 - 1;

    localparam int RAND_PHASES  = 12;
    localparam int PHASE_ITEMS  = 96;
    // receiver freezes once, after this many results, long enough to back up the input
    localparam int SQUEEZE_AT   = 400;
    localparam int SQUEEZE_HOLD = 2000;
    // Slowest correct run: one 65535-iteration item, ~1150 random items at a limit
    // of at most 600 with stalls, plus the freeze; the limit allows six times that.
    localparam int CYCLE_LIMIT  = 10_000_000;

    localparam logic signed [127:0] ESC_TWO  = 128'sd2 <<< FRAC_BITS;
    localparam logic signed [127:0] ESC_FOUR = 128'sd4 <<< (2 * FRAC_BITS);

    typedef struct packed {
        logic [LIMIT_W-1:0] count;
        logic               flag;
    } escape_t;

    // one directed stimulus row; res is only meaningful when known is set
    typedef struct packed {
        mbe_cfg_t         cfg;
        logic [PIX_W-1:0] x;
        logic [PIX_W-1:0] y;
        logic             known;
        escape_t          res;
    } dir_row_t;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                wr_en;
    logic [IDX_W-1:0]    wr_index;
    logic [CFG_W-1:0]    wr_data;
    logic                in_valid;
    logic                in_ready;
    logic [PIX_W-1:0]    pixel_x;
    logic [PIX_W-1:0]    pixel_y;
    logic                out_valid;
    logic                out_ready;
    logic [LIMIT_W-1:0]  iteration_count;
    logic                reached_limit;

    escape_t   escape_q[$];     // expected results, oldest first
    dir_row_t  dir_rows[$];
    mbe_cfg_t  live_cfg;        // predictor's copy of the registers
    bit        steady;          // phase runs without idle cycles on either side
    int        errors;
    int        cycles;
    escape_t   want;

    mandelbrot_escape_count DUT (
        .clk             (clk),
        .rst_n           (rst_n),
        .wr_en           (wr_en),
        .wr_index        (wr_index),
        .wr_data         (wr_data),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .pixel_x         (pixel_x),
        .pixel_y         (pixel_y),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .iteration_count (iteration_count),
        .reached_limit   (reached_limit)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ---------------------------------------------------------------- predictor

    // min + (max - min) * pos / size; magnitude divided and truncated, sign put
    // back afterwards, result clamped to 32 bit signed. Size 0 gives min.
    function automatic logic signed [63:0] axis_point(input logic signed [31:0] lo,
                                                      input logic signed [31:0] hi,
                                                      input logic [SIZE_W-1:0] size,
                                                      input logic [PIX_W-1:0] pos);
        logic signed [63:0] lo_w, hi_w, span, step, pt;
        logic [63:0]        mag, prod, quo;
        lo_w = lo;
        hi_w = hi;
        span = hi_w - lo_w;
        mag  = (span < 0) ? -span : span;
        prod = mag * pos;
        quo  = (size != 0) ? prod / size : 64'd0;
        step = (span < 0) ? -$signed(quo) : $signed(quo);
        pt   = lo_w + step;
        if (pt > 64'sd2147483647)
            pt = 64'sd2147483647;
        if (pt < -64'sd2147483648)
            pt = -64'sd2147483648;
        return pt;
    endfunction

    // Escape-time count for one pixel. Everything held at 128 bits so the
    // squares are exact; shifts are arithmetic, i.e. floor rounding.
    function automatic escape_t predict_escape(input mbe_cfg_t cfg,
                                               input logic [PIX_W-1:0] x,
                                               input logic [PIX_W-1:0] y);
        logic signed [127:0] cr, ci, zr, zi, ar, ai, sr, si, nr, ni;
        int unsigned         count;
        logic                escaped;
        escape_t             res;
        cr      = axis_point(cfg.re_lo, cfg.re_hi, cfg.image_width, x);
        ci      = axis_point(cfg.im_lo, cfg.im_hi, cfg.image_height, y);
        zr      = 0;
        zi      = 0;
        count   = 0;
        escaped = 1'b0;
        while (!escaped && count < cfg.iteration_limit)
        begin
            ar = (zr < 0) ? -zr : zr;
            ai = (zi < 0) ? -zi : zi;
            sr = ar * ar;
            si = ai * ai;
            // a component beyond 2 escapes at once, else the exact |z|^2 > 4 test
            if (ar > ESC_TWO || ai > ESC_TWO || sr + si > ESC_FOUR)
                escaped = 1'b1;
            else
            begin
                nr    = (sr - si) >>> FRAC_BITS;
                ni    = ((zr * zi) <<< 1) >>> FRAC_BITS;
                zr    = nr + cr;
                zi    = ni + ci;
                count = count + 1;
            end
        end
        res.count = count[LIMIT_W-1:0];
        res.flag  = (count == cfg.iteration_limit);
        return res;
    endfunction

    // ---------------------------------------------------------------- helpers

    function automatic mbe_cfg_t make_cfg(input int rmin, input int rmax,
                                          input int imin, input int imax,
                                          input int w, input int h, input int lim);
        mbe_cfg_t c;
        c.re_lo           = rmin;
        c.re_hi           = rmax;
        c.im_lo           = imin;
        c.im_hi           = imax;
        c.image_width     = w[SIZE_W-1:0];
        c.image_height    = h[SIZE_W-1:0];
        c.iteration_limit = lim[LIMIT_W-1:0];
        return c;
    endfunction

    task automatic add_row(input mbe_cfg_t cfg, input int x, input int y,
                           input logic known, input int count, input logic flag);
        dir_row_t r;
        r.cfg       = cfg;
        r.x         = x[PIX_W-1:0];
        r.y         = y[PIX_W-1:0];
        r.known     = known;
        r.res.count = count[LIMIT_W-1:0];
        r.res.flag  = flag;
        dir_rows.push_back(r);
    endtask

    // Drop valid and wait until every expected result has come back.
    // Each pixel gives exactly one result, so an empty queue means idle.
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (escape_q.size() != 0)
            @(posedge clk);
    endtask

    // One register write; the predictor copy is updated with the same masking.
    task automatic write_reg(input mbe_reg_idx_t idx, input logic [CFG_W-1:0] data);
        wr_en    <= 1'b1;
        wr_index <= idx;
        wr_data  <= data;
        case (idx)
            REG_RE_LO:      live_cfg.re_lo           = data;
            REG_RE_HI:      live_cfg.re_hi           = data;
            REG_IM_LO:      live_cfg.im_lo           = data;
            REG_IM_HI:      live_cfg.im_hi           = data;
            REG_WIDTH:      live_cfg.image_width     = data[SIZE_W-1:0];
            REG_HEIGHT:     live_cfg.image_height    = data[SIZE_W-1:0];
            REG_ITER_LIMIT: live_cfg.iteration_limit = data[LIMIT_W-1:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic load_cfg(input mbe_cfg_t cfg);
        wait_idle();
        write_reg(REG_RE_LO,      cfg.re_lo);
        write_reg(REG_RE_HI,      cfg.re_hi);
        write_reg(REG_IM_LO,      cfg.im_lo);
        write_reg(REG_IM_HI,      cfg.im_hi);
        write_reg(REG_WIDTH,      CFG_W'(cfg.image_width));
        write_reg(REG_HEIGHT,     CFG_W'(cfg.image_height));
        write_reg(REG_ITER_LIMIT, CFG_W'(cfg.iteration_limit));
        wr_en <= 1'b0;
    endtask

    // Offer one pixel item after a random gap; valid stays up (payload held)
    // until accepted. A zero gap keeps valid high straight into the next item.
    task automatic offer_pixel(input logic [PIX_W-1:0] x, input logic [PIX_W-1:0] y,
                               input logic known, input escape_t typed);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 5);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        pixel_x  <= x;
        pixel_y  <= y;
        do
            @(posedge clk);
        while (!in_ready);
        escape_q.push_back(known ? typed : predict_escape(live_cfg, x, y));
    endtask

    // ---------------------------------------------------------------- stimulus

    initial
    begin : stimulus
        mbe_cfg_t         cfg_reset, cfg_nolim, cfg_one, cfg_flat, cfg_edge, cfg_wide;
        mbe_cfg_t         cfg_mirror, rnd_cfg;
        logic [PIX_W-1:0] px, py;
        int               rc, ic, rh, ih, rmin, rmax, imin, imax, w, h, lim, sel;

        rst_n    = 1'b0;
        wr_en    = 1'b0;
        wr_index = REG_RE_LO;
        wr_data  = '0;
        in_valid = 1'b0;
        pixel_x  = '0;
        pixel_y  = '0;
        steady   = 1'b0;
        errors   = 0;

        // register defaults after reset: [-2, 2] x [-1.5, 1.5], 640 x 480, 256
        cfg_reset  = make_cfg(-2 * ONE, 2 * ONE, -(3 * ONE / 2), 3 * ONE / 2, 640, 480, 256);
        live_cfg   = cfg_reset;
        cfg_nolim  = cfg_reset;
        cfg_nolim.iteration_limit = '0;
        cfg_one    = cfg_reset;
        cfg_one.iteration_limit   = 1;
        // zero sizes pin c to min = 0: never escapes, full 16 bit limit
        cfg_flat   = make_cfg(0, Q_MAX, 0, Q_MIN, 0, 0, 65535);
        // full-range spans over a single pixel: results clamp at both ends
        cfg_edge   = make_cfg(Q_MIN, Q_MAX, Q_MAX, Q_MIN, 1, 1, 16);
        cfg_wide   = make_cfg(-2 * ONE, ONE / 2, -(5 * ONE / 4), 5 * ONE / 4, 4096, 4096, 64);
        // min above max: axes mirrored
        cfg_mirror = make_cfg(ONE / 2, -2 * ONE, 5 * ONE / 4, -(5 * ONE / 4), 100, 100, 200);

        // known results: corner escapes after one step, exact center never does
        add_row(cfg_reset,  0,    0,    1'b1, 1,     1'b0);
        add_row(cfg_reset,  320,  240,  1'b1, 256,   1'b1);
        add_row(cfg_reset,  639,  479,  1'b0, 0,     1'b0);
        add_row(cfg_reset,  4095, 4095, 1'b0, 0,     1'b0);
        add_row(cfg_reset,  2048, 1365, 1'b0, 0,     1'b0);
        // zero limit: nothing runs, flag set
        add_row(cfg_nolim,  320,  240,  1'b1, 0,     1'b1);
        add_row(cfg_nolim,  0,    0,    1'b1, 0,     1'b1);
        add_row(cfg_one,    0,    0,    1'b1, 1,     1'b1);
        add_row(cfg_one,    4095, 0,    1'b1, 1,     1'b1);
        add_row(cfg_edge,   0,    0,    1'b1, 1,     1'b0);
        add_row(cfg_edge,   1,    1,    1'b1, 1,     1'b0);
        add_row(cfg_edge,   4095, 4095, 1'b1, 1,     1'b0);
        add_row(cfg_wide,   0,    0,    1'b0, 0,     1'b0);
        add_row(cfg_wide,   4095, 4095, 1'b0, 0,     1'b0);
        add_row(cfg_wide,   2048, 2048, 1'b0, 0,     1'b0);
        add_row(cfg_wide,   1234, 3000, 1'b0, 0,     1'b0);
        add_row(cfg_wide,   2861, 1095, 1'b0, 0,     1'b0);
        add_row(cfg_mirror, 10,   50,   1'b0, 0,     1'b0);
        add_row(cfg_mirror, 99,   0,    1'b0, 0,     1'b0);
        add_row(cfg_mirror, 50,   50,   1'b0, 0,     1'b0);
        add_row(cfg_flat,   4095, 4095, 1'b1, 65535, 1'b1);

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part; the first rows run on the reset values, no writes
        foreach (dir_rows[i])
        begin
            if (dir_rows[i].cfg != live_cfg)
                load_cfg(dir_rows[i].cfg);
            offer_pixel(dir_rows[i].x, dir_rows[i].y, dir_rows[i].known, dir_rows[i].res);
        end

        // random phases: mostly windows around the set, zoomed at random scales
        // so counts spread out; now and then a fully random or mirrored window
        for (int ph = 0; ph < RAND_PHASES; ph++)
        begin
            rc  = int'($urandom_range(0, 5 * ONE / 2)) - 2 * ONE;
            ic  = int'($urandom_range(0, 2 * ONE)) - ONE;
            rh  = (1 << $urandom_range(12, 29)) + int'($urandom_range(0, 4095));
            ih  = (1 << $urandom_range(12, 29)) + int'($urandom_range(0, 4095));
            sel = $urandom_range(0, 9);
            if (sel == 0)
            begin
                rmin = $urandom;
                rmax = $urandom;
                imin = $urandom;
                imax = $urandom;
            end
            else if (sel == 1)
            begin
                rmin = rc + rh;
                rmax = rc - rh;
                imin = ic + ih;
                imax = ic - ih;
            end
            else
            begin
                rmin = rc - rh;
                rmax = rc + rh;
                imin = ic - ih;
                imax = ic + ih;
            end
            sel = $urandom_range(0, 7);
            w   = (sel == 0) ? 4096 : (sel == 1) ? 1 : $urandom_range(2, 200);
            sel = $urandom_range(0, 7);
            h   = (sel == 0) ? 4096 : (sel == 1) ? 1 : $urandom_range(2, 200);
            case ($urandom_range(0, 9))
                0:       lim = 1;
                1, 2:    lim = $urandom_range(2, 16);
                3:       lim = 256;
                4:       lim = $urandom_range(300, 600);
                default: lim = $urandom_range(17, 300);
            endcase
            rnd_cfg = make_cfg(rmin, rmax, imin, imax, w, h, lim);
            load_cfg(rnd_cfg);
            steady = ($urandom_range(0, 4) == 0);

            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                // one in ten coordinates ignores the image size
                px = ($urandom_range(0, 9) == 0) ? PIX_W'($urandom)
                   : PIX_W'($urandom_range(0, live_cfg.image_width - 1));
                py = ($urandom_range(0, 9) == 0) ? PIX_W'($urandom)
                   : PIX_W'($urandom_range(0, live_cfg.image_height - 1));
                offer_pixel(px, py, 1'b0, '0);
            end
        end

        wait_idle();
        // a stray extra result would show up within one more item latency
        repeat (2 * live_cfg.iteration_limit + 100) @(posedge clk);
        if (errors == 0)
            $display("mandelbrot_escape_count: match");
        else
            $display("mandelbrot_escape_count: mismatch");
        $finish;
    end

    // ---------------------------------------------------------------- result side

    // Ready drops for a random hold before each item unless the phase is steady; once, a long
    // freeze while the sender keeps offering, so the DUT fills and holds in_ready low.
    initial
    begin : result_sink
        int hold;
        int taken;
        bit squeezed;
        taken     = 0;
        squeezed  = 1'b0;
        out_ready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            hold = steady ? 0 : $urandom_range(0, 5);
            if (!squeezed && taken >= SQUEEZE_AT)
            begin
                hold     = SQUEEZE_HOLD;
                squeezed = 1'b1;
            end
            if (hold != 0)
            begin
                out_ready <= 1'b0;
                repeat (hold) @(posedge clk);
            end
            out_ready <= 1'b1;
            do
                @(posedge clk);
            while (!out_valid);
            taken = taken + 1;
        end
    end

    // compare each accepted result with the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (escape_q.size() == 0)
            begin
                errors = errors + 1;
                $display("%0t: unexpected result, expected none, actual count %0d flag %0d",
                         $time, iteration_count, reached_limit);
            end
            else
            begin
                want = escape_q.pop_front();
                if (iteration_count !== want.count)
                begin
                    errors = errors + 1;
                    $display("%0t: iteration_count expected %0d actual %0d",
                             $time, want.count, iteration_count);
                end
                if (reached_limit !== want.flag)
                begin
                    errors = errors + 1;
                    $display("%0t: reached_limit expected %0d actual %0d",
                             $time, want.flag, reached_limit);
                end
            end
        end
    end

    // watchdog
    initial
        cycles = 0;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("mandelbrot_escape_count: mismatch");
            $finish;
        end
    end

endmodule
